// ===== rtl/hrl_pkg.sv =====
`default_nettype none

package hrl_pkg;

    // Field and port widths
    localparam int CHAR_W   = 8;
    localparam int LIMIT_W  = 21;
    localparam int ADDR_W   = 20;
    localparam int DATA_W   = 8;
    localparam int WORD16_W = 16;
    localparam int TDATA_W  = 64;
    localparam int TUSER_W  = 2;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    // Register defaults and sizing
    localparam logic [LIMIT_W-1:0] MEM_LIMIT_RST   = 21'h10000;
    localparam int                 QUEUE_DEPTH_DEF = 2;

    // Record types that are carried out (anything above START is unsupported)
    localparam logic [1:0] RT_DATA  = 2'd0;
    localparam logic [1:0] RT_EOF   = 2'd1;
    localparam logic [1:0] RT_SEG   = 2'd2;
    localparam logic [1:0] RT_START = 2'd3;

    // Character classes handed from the front to the back
    typedef enum logic [1:0] {
        TOK_EOL,
        TOK_COLON,
        TOK_HEX,
        TOK_BAD
    } t_tok_kind;

    typedef struct packed {
        t_tok_kind   kind;
        logic [3:0]  nib;
    } t_token;

    // Result kinds
    typedef enum logic [1:0] {
        RES_WRITE  = 2'd0,
        RES_STATUS = 2'd1,
        RES_START  = 2'd2
    } t_res_kind;

    // Record status codes
    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_EOF         = 3'd1,
        ST_FORMAT      = 3'd2,
        ST_CHECKSUM    = 3'd3,
        ST_NO_MEMORY   = 3'd4,
        ST_UNSUPPORTED = 3'd5
    } t_status;

    typedef struct packed {
        t_res_kind             kind;
        logic [ADDR_W-1:0]     addr;
        logic [DATA_W-1:0]     data;
        t_status               status;
        logic [WORD16_W-1:0]   seg;
        logic [WORD16_W-1:0]   off;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/hrl_front.sv =====
`default_nettype none

module hrl_front #(
    parameter int DEPTH = hrl_pkg::QUEUE_DEPTH_DEF   // 2 or more
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_s_tvalid,
    output logic                            o_s_tready,
    input  wire logic [hrl_pkg::CHAR_W-1:0] i_s_tdata,
    output logic                            o_tok_valid,
    output hrl_pkg::t_token                 o_tok,
    input  wire logic                       i_tok_pop
);
    import hrl_pkg::*;

    localparam int             PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int             CW   = $clog2(DEPTH + 1);
    localparam logic [PW-1:0]  LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0]  FULL = CW'(DEPTH);

    localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UF    = 8'h46;
    localparam logic [CHAR_W-1:0] CHAR_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LF_HEX = 8'h66;

    t_token          r_mem [DEPTH];
    logic [PW-1:0]   r_wr;
    logic [PW-1:0]   r_rd;
    logic [CW-1:0]   r_cnt;
    t_token          w_tok;
    logic            w_push;

    // Classify the incoming character
    always_comb begin
        w_tok.kind = TOK_BAD;
        w_tok.nib  = 4'h0;
        priority if (i_s_tdata >= CHAR_0 && i_s_tdata <= CHAR_9) begin
            w_tok.kind = TOK_HEX;
            w_tok.nib  = i_s_tdata[3:0];
        end else if ((i_s_tdata >= CHAR_UA && i_s_tdata <= CHAR_UF) ||
                     (i_s_tdata >= CHAR_LA && i_s_tdata <= CHAR_LF_HEX)) begin
            w_tok.kind = TOK_HEX;
            w_tok.nib  = i_s_tdata[3:0] + 4'd9;
        end else if (i_s_tdata == CHAR_COLON) begin
            w_tok.kind = TOK_COLON;
        end else if (i_s_tdata == CHAR_CR || i_s_tdata == CHAR_LF) begin
            w_tok.kind = TOK_EOL;
        end else begin
            w_tok.kind = TOK_BAD;
        end
    end

    assign o_s_tready  = (r_cnt != FULL);
    assign w_push      = i_s_tvalid && o_s_tready;
    assign o_tok_valid = (r_cnt != '0);
    assign o_tok       = r_mem[r_rd];

    // Store classified words
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= w_tok;
        end
    end

    // Advance queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == LAST) ? '0 : r_wr + PW'(1);
            end
            if (i_tok_pop) begin
                r_rd <= (r_rd == LAST) ? '0 : r_rd + PW'(1);
            end
            if (w_push && !i_tok_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (!w_push && i_tok_pop) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/hrl_back.sv =====
`default_nettype none

module hrl_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_tok_valid,
    input  wire hrl_pkg::t_token             i_tok,
    output logic                             o_tok_pop,
    input  wire logic [hrl_pkg::LIMIT_W-1:0] i_mem_limit,
    output logic                             o_m_tvalid,
    input  wire logic                        i_m_tready,
    output hrl_pkg::t_result                 o_res
);
    import hrl_pkg::*;

    typedef enum logic [1:0] {
        PH_COLON,
        PH_HEADER,
        PH_DATA,
        PH_CHECK
    } t_phase;

    t_phase                r_phase,  n_phase;
    logic                  r_nib,    n_nib;
    logic [3:0]            r_hi,     n_hi;
    logic [7:0]            r_len,    n_len;
    logic [WORD16_W-1:0]   r_off,    n_off;
    logic [1:0]            r_type,   n_type;
    logic [7:0]            r_sum,    n_sum;
    logic [7:0]            r_bd,     n_bd;
    logic [WORD16_W-1:0]   r_seg,    n_seg;
    logic [31:0]           r_word,   n_word;
    logic                  r_rerr,   n_rerr;
    logic                  r_stopped, n_stopped;
    logic                  r_out_valid;
    t_result               r_res,    n_res;
    logic                  n_emit;

    logic                  w_fire;
    logic [7:0]            w_byte;
    logic [7:0]            w_sum;
    logic [7:0]            w_bd_inc;
    logic [ADDR_W-1:0]     w_addr;
    logic                  w_no_mem;

    assign w_fire    = i_tok_valid && (!r_out_valid || i_m_tready);
    assign o_tok_pop = w_fire;
    assign w_byte    = {r_hi, i_tok.nib};
    assign w_sum     = r_sum + w_byte;
    assign w_bd_inc  = r_bd + 8'd1;
    assign w_addr    = {r_seg, 4'h0} + {4'h0, r_off};
    assign w_no_mem  = ({1'b0, w_addr} >= i_mem_limit);

    assign o_m_tvalid = r_out_valid;
    assign o_res      = r_res;

    // Parse one classified word
    always_comb begin
        n_phase   = r_phase;
        n_nib     = r_nib;
        n_hi      = r_hi;
        n_len     = r_len;
        n_off     = r_off;
        n_type    = r_type;
        n_sum     = r_sum;
        n_bd      = r_bd;
        n_seg     = r_seg;
        n_word    = r_word;
        n_rerr    = r_rerr;
        n_stopped = r_stopped;
        n_emit    = 1'b0;
        n_res     = '0;

        if (w_fire && !r_stopped) begin
            if (r_phase == PH_COLON) begin
                // Skip line ends, open a record on colon, stop on anything else
                priority if (i_tok.kind == TOK_EOL) begin
                    n_phase = PH_COLON;
                end else if (i_tok.kind == TOK_COLON) begin
                    n_phase = PH_HEADER;
                    n_nib   = 1'b0;
                    n_sum   = '0;
                    n_bd    = '0;
                    n_word  = '0;
                    n_rerr  = 1'b0;
                end else begin
                    n_emit       = 1'b1;
                    n_res.kind   = RES_STATUS;
                    n_res.status = ST_FORMAT;
                    n_stopped    = 1'b1;
                end
            end else if (i_tok.kind != TOK_HEX) begin
                n_phase      = PH_COLON;
                n_emit       = 1'b1;
                n_res.kind   = RES_STATUS;
                n_res.status = ST_FORMAT;
                n_stopped    = 1'b1;
            end else if (!r_nib) begin
                n_hi  = i_tok.nib;
                n_nib = 1'b1;
            end else begin
                n_nib = 1'b0;
                n_sum = w_sum;
                unique case (r_phase)
                    PH_HEADER: begin
                        n_bd = w_bd_inc;
                        unique case (r_bd[1:0])
                            2'd0: n_len = w_byte;
                            2'd1: n_off[15:8] = w_byte;
                            2'd2: n_off[7:0]  = w_byte;
                            default: begin
                                n_type = w_byte[1:0];
                                n_bd   = '0;
                                if (w_byte > {6'b0, RT_START}) begin
                                    n_phase      = PH_COLON;
                                    n_emit       = 1'b1;
                                    n_res.kind   = RES_STATUS;
                                    n_res.status = ST_UNSUPPORTED;
                                    n_stopped    = 1'b1;
                                end else begin
                                    n_phase = (r_len != '0) ? PH_DATA : PH_CHECK;
                                end
                            end
                        endcase
                    end
                    PH_DATA: begin
                        // Collect the data byte and write it for data records that fall below the memory limit
                        n_word = {r_word[23:0], w_byte};
                        n_bd   = w_bd_inc;
                        n_off  = r_off + 16'd1;
                        if (w_bd_inc == r_len) begin
                            n_phase = PH_CHECK;
                        end
                        if (r_type == RT_DATA) begin
                            if (w_no_mem) begin
                                n_rerr = 1'b1;
                            end else begin
                                n_emit     = 1'b1;
                                n_res.kind = RES_WRITE;
                                n_res.addr = w_addr;
                                n_res.data = w_byte;
                            end
                        end
                    end
                    PH_CHECK: begin
                        // Close the record on its checksum byte
                        n_phase = PH_COLON;
                        n_emit  = 1'b1;
                        n_res.kind = RES_STATUS;
                        if (w_sum != '0) begin
                            n_res.status = ST_CHECKSUM;
                            n_stopped    = 1'b1;
                        end else begin
                            unique case (r_type)
                                RT_DATA: begin
                                    n_res.status = r_rerr ? ST_NO_MEMORY : ST_OK;
                                    n_stopped    = r_rerr;
                                end
                                RT_EOF: begin
                                    n_res.status = ST_EOF;
                                    n_stopped    = 1'b1;
                                end
                                RT_SEG: begin
                                    n_seg        = r_word[15:0];
                                    n_res.status = ST_OK;
                                end
                                default: begin
                                    n_res.kind = RES_START;
                                    n_res.seg  = r_word[31:16];
                                    n_res.off  = r_word[15:0];
                                end
                            endcase
                        end
                    end
                    default: n_phase = PH_COLON;
                endcase
            end
        end
    end

    // Hold parser state and the output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_COLON;
            r_nib       <= 1'b0;
            r_hi        <= '0;
            r_len       <= '0;
            r_off       <= '0;
            r_type      <= RT_DATA;
            r_sum       <= '0;
            r_bd        <= '0;
            r_seg       <= '0;
            r_word      <= '0;
            r_rerr      <= 1'b0;
            r_stopped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_nib     <= n_nib;
            r_hi      <= n_hi;
            r_len     <= n_len;
            r_off     <= n_off;
            r_type    <= n_type;
            r_sum     <= n_sum;
            r_bd      <= n_bd;
            r_seg     <= n_seg;
            r_word    <= n_word;
            r_rerr    <= n_rerr;
            r_stopped <= n_stopped;
            if (w_fire) begin
                r_out_valid <= n_emit;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Load the result payload
    always_ff @(posedge i_clk) begin
        if (w_fire && n_emit) begin
            r_res <= n_res;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/hex_record_loader.sv =====
// Channel   | Dir | Handshake          | Payload
// ----------+-----+--------------------+-------------------------------------------
// s stream  | in  | tvalid / tready    | tdata[7:0] text_char
// m stream  | out | tvalid / tready    | tuser: result_kind; tdata: address, data,
//           |     |                    |   status, start segment, start offset
// APB       | in  | psel/penable/pready| reg 0 at 0x0: memory_limit[20:0]
//
// One character per cycle sustained while the output is not stalled; a result
// passes through the character queue and then the parser's output register.
// Throughput is set by the parser, which retires one queued character per cycle
// whenever the output register is empty or being drained.
// Reset is synchronous; no clearing pass is needed.
// Either side may stall on its own: the character queue absorbs input while
// the output register waits.
`default_nettype none

module hex_record_loader #(
    parameter int QUEUE_DEPTH = hrl_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // tdata: [7:0] text_char
    input  wire logic                        i_s_tvalid,
    output logic                             o_s_tready,
    input  wire logic [hrl_pkg::CHAR_W-1:0]  i_s_tdata,
    // tdata: [19:0] write_address, [27:20] write_data, [30:28] status_code,
    //        [46:31] start_segment, [62:47] start_offset, [63] zero
    output logic                             o_m_tvalid,
    input  wire logic                        i_m_tready,
    output logic [hrl_pkg::TDATA_W-1:0]      o_m_tdata,
    // tuser: [1:0] result_kind
    output logic [hrl_pkg::TUSER_W-1:0]      o_m_tuser,
    input  wire logic                        i_psel,
    input  wire logic                        i_penable,
    input  wire logic                        i_pwrite,
    input  wire logic [hrl_pkg::APB_AW-1:0]  i_paddr,
    input  wire logic [hrl_pkg::APB_DW-1:0]  i_pwdata,
    output logic [hrl_pkg::APB_DW-1:0]       o_prdata,
    output logic                             o_pready
);
    import hrl_pkg::*;

    logic [LIMIT_W-1:0] r_mem_limit;
    logic               w_sel_limit;
    logic               w_tok_valid;
    t_token             w_tok;
    logic               w_tok_pop;
    t_result            w_res;

    // Register file: one word, selected by the word address
    assign o_pready    = 1'b1;
    assign w_sel_limit = (i_paddr[APB_AW-1:2] == '0);
    assign o_prdata    = w_sel_limit ? {{(APB_DW-LIMIT_W){1'b0}}, r_mem_limit} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_limit <= MEM_LIMIT_RST;
        end else if (i_psel && i_penable && i_pwrite && o_pready && w_sel_limit) begin
            r_mem_limit <= i_pwdata[LIMIT_W-1:0];
        end
    end

    hrl_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_tok_valid (w_tok_valid),
        .o_tok       (w_tok),
        .i_tok_pop   (w_tok_pop)
    );

    hrl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (w_tok_valid),
        .i_tok       (w_tok),
        .o_tok_pop   (w_tok_pop),
        .i_mem_limit (r_mem_limit),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_res       (w_res)
    );

    // Pack the result word
    assign o_m_tuser = w_res.kind;
    assign o_m_tdata = {1'b0, w_res.off, w_res.seg, w_res.status, w_res.data, w_res.addr};

endmodule

`default_nettype wire

// ===== rtl/hrl_checker.sv =====
`default_nettype none

module hrl_checker (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        o_m_tvalid,
    input  wire logic                        i_m_tready,
    input  wire logic [hrl_pkg::TDATA_W-1:0] o_m_tdata,
    input  wire logic [hrl_pkg::TUSER_W-1:0] o_m_tuser
);
    import hrl_pkg::*;

    // Hold a stalled output word
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("output word changed under stall");

    // A memory write carries only address and data
    a_write_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == RES_WRITE |-> o_m_tdata[63:28] == '0)
        else $error("write word carries status or start fields");

    // A status word carries only the status code
    a_status_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == RES_STATUS |->
            o_m_tdata[27:0] == '0 && o_m_tdata[63:31] == '0)
        else $error("status word carries write or start fields");

    // Drop everything after a load-ending status
    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && o_m_tuser == RES_STATUS && o_m_tdata[30:28] != ST_OK
        |=> !o_m_tvalid)
        else $error("result after load ended");

endmodule

bind hex_record_loader hrl_checker u_hrl_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

`default_nettype wire
